>>> sv/mlqs_pkg.sv
// Package for the multilevel queue scheduler: beat structs, commands, sizes.
// No dependencies.
package mlqs_pkg;
	localparam int MAX_TASKS = 64;
	localparam int TIME_BITS = 16;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic REG_QUANTUM    = 1'b0;
	localparam logic REG_TASK_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  task_index;
		logic [15:0] arrival_time;
		logic [15:0] work_length;
		logic [2:0]  urgency;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] slot_time;
		logic [5:0]  running_task;
		logic        idle;
		logic        first_dispatch;
		logic        finished;
		logic        all_done;
	} out_beat_t;
endpackage

>>> sv/mlqs_task_mem.sv
// Task table: arrival, remaining work and urgency per entry, one write and
// one registered read port. Depends on nothing.
module mlqs_task_mem #(
	parameter int MAX_TASKS = 64,
	parameter int TIME_BITS = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(MAX_TASKS)-1:0] waddr,
	input  logic [TIME_BITS-1:0]         warr,
	input  logic [15:0]                  wrem,
	input  logic [2:0]                   wurg,
	input  logic [$clog2(MAX_TASKS)-1:0] raddr,
	output logic [TIME_BITS-1:0]         rarr,
	output logic [15:0]                  rrem,
	output logic [2:0]                   rurg
);
	logic [TIME_BITS+18:0] mem [MAX_TASKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {warr, wrem, wurg};
		end
		{rarr, rrem, rurg} <= mem[raddr];
	end
endmodule

>>> sv/mlqs_ring_mem.sv
// Level rings: task numbers per level, one write and one registered read.
// Depends on nothing.
module mlqs_ring_mem #(
	parameter int DEPTH = 512,
	parameter int W     = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/multilevel_queue_scheduler.sv
// Top level of the multilevel queue scheduler: sequencer, marks, ring heads.
// Depends on mlqs_pkg, mlqs_task_mem and mlqs_ring_mem.
//
// A load beat writes its task table entry; a clear beat resets the rings,
// marks and slot time. A tick beat with tasks still unfinished walks the
// participating entries one at a time through the task table read port
// (read, then enqueue into the level ring memory), then handles preemption,
// requeue, dispatch and the work update; with all tasks done it ends with no
// output beat. The single table port serializes the walk. The result sits
// in an output register; the next beat is taken once it has been handed off.
module multilevel_queue_scheduler #(
	parameter int LEVELS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mlqs_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mlqs_pkg::out_beat_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [6:0]          cfg_data
);
	import mlqs_pkg::*;

	localparam int TW = $clog2(MAX_TASKS);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int FW = TW + 1;
	localparam int RD = LEVELS * MAX_TASKS;
	localparam int RW = $clog2(RD);
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRD    = 4'd1;
	localparam logic [3:0] S_SCHK   = 4'd2;
	localparam logic [3:0] S_PRE    = 4'd3;
	localparam logic [3:0] S_CRD    = 4'd4;
	localparam logic [3:0] S_REQ    = 4'd5;
	localparam logic [3:0] S_POP    = 4'd6;
	localparam logic [3:0] S_POPW   = 4'd7;
	localparam logic [3:0] S_DRD    = 4'd8;
	localparam logic [3:0] S_DRDW   = 4'd9;
	localparam logic [3:0] S_RUN    = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;
	localparam logic [3:0] S_CHK    = 4'd13;

	logic [3:0] state_q;
	in_beat_t   beat_q;
	logic [3:0] quantum_q;
	logic [6:0] count_q;
	logic [MAX_TASKS-1:0] started_q, enq_q;
	logic [TW-1:0] head_q [LEVELS];
	logic [FW-1:0] fill_q [LEVELS];
	logic [TW-1:0] cur_q;
	logic          curv_q;
	logic [3:0]    slice_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [6:0]    done_q;
	logic [FW-1:0] idx_q;
	logic          first_q, fin_q, ran_q;
	logic [TW-1:0] run_q;
	logic          pend_q;
	out_beat_t     obuf_q;
	logic          ovld_q;

	// task table ports
	logic          t_we;
	logic [TW-1:0] t_waddr, t_raddr;
	logic [TIME_BITS-1:0] t_warr, t_rarr;
	logic [15:0]   t_wrem, t_rrem;
	logic [2:0]    t_wurg, t_rurg;

	logic          r_we;
	logic [RW-1:0] r_waddr, r_raddr;
	logic [TW-1:0] r_wdata, r_rdata;

	mlqs_task_mem #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS)) u_task (
		.clk(clk), .we(t_we), .waddr(t_waddr), .warr(t_warr), .wrem(t_wrem),
		.wurg(t_wurg), .raddr(t_raddr), .rarr(t_rarr), .rrem(t_rrem), .rurg(t_rurg)
	);

	mlqs_ring_mem #(.DEPTH(RD), .W(TW)) u_ring (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	logic [6:0]  cnt;
	logic [LW-1:0] rlev;
	logic [LW-1:0] top_lv;
	logic          top_any;
	logic [TW:0]   pos_sum;
	logic [TW-1:0] push_pos;
	logic          push_ok;
	logic [TW-1:0] push_task;

	always_comb begin
		cnt = (count_q > 7'(MAX_TASKS)) ? 7'(MAX_TASKS) : count_q;
		rlev = (32'(t_rurg) < LEVELS) ? LW'(t_rurg) : LW'(LEVELS - 1);
		top_any = 1'b0;
		top_lv = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (fill_q[l] != '0) begin
				top_any = 1'b1;
				top_lv = LW'(l);
			end
		end
	end

	// push target: scan entry during the arrival walk, else the current task
	always_comb begin
		push_task = (state_q == S_SCHK) ? idx_q[TW-1:0] : cur_q;
		pos_sum = {1'b0, head_q[rlev]} + fill_q[rlev];
		push_pos = (pos_sum >= (TW+1)'(MAX_TASKS)) ?
			TW'(pos_sum - (TW+1)'(MAX_TASKS)) : pos_sum[TW-1:0];
		push_ok = !enq_q[push_task] && (fill_q[rlev] < FW'(MAX_TASKS));
	end

	logic scan_hit, pre_hit, req_do;
	always_comb begin
		scan_hit = (t_rarr <= tick_q) && (t_rrem != '0) && !(curv_q && cur_q == idx_q[TW-1:0]);
		pre_hit  = curv_q && top_any && (top_lv > rlev);
		req_do   = curv_q && (slice_q >= quantum_q) && (t_rrem != '0);
	end

	always_comb begin
		t_we = 1'b0;
		t_waddr = beat_q.task_index[TW-1:0];
		t_warr = TIME_BITS'(beat_q.arrival_time);
		t_wrem = beat_q.work_length;
		t_wurg = beat_q.urgency;
		t_raddr = cur_q;
		r_we = 1'b0;
		r_waddr = RW'({rlev, push_pos});
		r_wdata = push_task;
		r_raddr = RW'({top_lv, head_q[top_lv]});
		unique case (state_q)
			S_IDLE: begin
				t_we = 1'b0;
			end
			S_SRD: t_raddr = idx_q[TW-1:0];
			S_SCHK: r_we = scan_hit && push_ok;
			S_PRE: r_we = pre_hit && push_ok;
			S_REQ: r_we = req_do && push_ok;
			S_RUN: begin
				t_we = 1'b1;
				t_waddr = cur_q;
				t_warr = t_rarr;
				t_wrem = (t_rrem != '0) ? t_rrem - 16'd1 : t_rrem;
				t_wurg = t_rurg;
			end
			S_DONE: t_we = (32'(beat_q.task_index) < MAX_TASKS);
			default: t_we = 1'b0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE) && !ovld_q;
	assign out_valid = ovld_q;
	assign out_data = obuf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			beat_q <= '0;
			quantum_q <= 4'd2;
			count_q <= '0;
			started_q <= '0;
			enq_q <= '0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				fill_q[l] <= '0;
			end
			cur_q <= '0;
			curv_q <= 1'b0;
			slice_q <= '0;
			tick_q <= '0;
			done_q <= '0;
			idx_q <= '0;
			first_q <= 1'b0;
			fin_q <= 1'b0;
			ran_q <= 1'b0;
			run_q <= '0;
			pend_q <= 1'b0;
			obuf_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_QUANTUM) begin
					quantum_q <= cfg_data[3:0];
				end else begin
					count_q <= cfg_data;
				end
			end
			if (ovld_q && out_ready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						beat_q <= in_data;
						idx_q <= '0;
						first_q <= 1'b0;
						fin_q <= 1'b0;
						ran_q <= 1'b0;
						pend_q <= 1'b0;
						unique case (in_data.cmd)
							CMD_LOAD: state_q <= S_DONE;
							CMD_TICK: state_q <= S_CHK;
							CMD_CLEAR: begin
								started_q <= '0;
								enq_q <= '0;
								for (int l = 0; l < LEVELS; l++) begin
									head_q[l] <= '0;
									fill_q[l] <= '0;
								end
								cur_q <= '0;
								curv_q <= 1'b0;
								slice_q <= '0;
								tick_q <= '0;
								done_q <= '0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CHK: state_q <= (done_q >= cnt) ? S_IDLE :
					((cnt == '0) ? S_CRD : S_SRD);
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (scan_hit && push_ok) begin
						fill_q[rlev] <= fill_q[rlev] + 1'b1;
						enq_q[push_task] <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 >= FW'(cnt)) ? S_CRD : S_SRD;
				end
				S_CRD: state_q <= S_PRE;
				S_PRE: begin
					state_q <= S_CRD;
					pend_q <= 1'b1;
					if (!pend_q) begin
						if (pre_hit) begin
							if (push_ok) begin
								fill_q[rlev] <= fill_q[rlev] + 1'b1;
								enq_q[push_task] <= 1'b1;
							end
							curv_q <= 1'b0;
							slice_q <= '0;
						end
					end else begin
						state_q <= S_REQ;
					end
				end
				S_REQ: begin
					if (!curv_q || slice_q >= quantum_q) begin
						if (req_do && push_ok) begin
							fill_q[rlev] <= fill_q[rlev] + 1'b1;
							enq_q[push_task] <= 1'b1;
						end
						curv_q <= 1'b0;
						slice_q <= '0;
						state_q <= S_POP;
					end else begin
						state_q <= S_DRD;
					end
				end
				S_POP: state_q <= S_POPW;
				S_POPW: begin
					if (top_any) begin
						cur_q <= r_rdata;
						curv_q <= 1'b1;
						head_q[top_lv] <= (32'(head_q[top_lv]) == MAX_TASKS - 1) ?
							'0 : head_q[top_lv] + 1'b1;
						fill_q[top_lv] <= fill_q[top_lv] - 1'b1;
						enq_q[r_rdata] <= 1'b0;
						if (!started_q[r_rdata]) begin
							started_q[r_rdata] <= 1'b1;
							first_q <= 1'b1;
						end
					end
					state_q <= S_DRD;
				end
				S_DRD: state_q <= S_DRDW;
				S_DRDW: state_q <= curv_q ? S_RUN : S_OUT;
				S_RUN: begin
					ran_q <= 1'b1;
					run_q <= cur_q;
					if (slice_q != 4'd15) begin
						slice_q <= slice_q + 1'b1;
					end
					if (t_rrem <= 16'd1) begin
						fin_q <= 1'b1;
						if (done_q != 7'd127) begin
							done_q <= done_q + 1'b1;
						end
						curv_q <= 1'b0;
						slice_q <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					obuf_q.slot_time <= 16'(tick_q);
					obuf_q.running_task <= ran_q ? 6'(run_q) : 6'd0;
					obuf_q.idle <= !ran_q;
					obuf_q.first_dispatch <= ran_q && first_q;
					obuf_q.finished <= ran_q && fin_q;
					obuf_q.all_done <= (done_q >= cnt);
					ovld_q <= 1'b1;
					if (tick_q != TIME_MAX) begin
						tick_q <= tick_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
